// File: hdl/uart_command_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command frame parser.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
// ----------------------------------------------------------------------------
`ifndef UART_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define UCFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define UCFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define UCFP_ASSERT(label, prop, msg)
`define UCFP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/ucfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfp_pkg
// Byte codes and result kinds of the command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

    localparam logic [7:0] BYTE_HDR_FIRST  = 8'hAA;
    localparam logic [7:0] BYTE_HDR_SECOND = 8'hEE;
    localparam logic [7:0] BYTE_TRAILER    = 8'hAE;

    localparam logic [7:0] CODE_MODE  = 8'hB0;
    localparam logic [7:0] CODE_TASK  = 8'hC0;
    localparam logic [7:0] CODE_BACK  = 8'hC1;
    localparam logic [7:0] CODE_START = 8'hC2;
    localparam logic [7:0] CODE_PUMP  = 8'hD0;
    localparam logic [7:0] CODE_MOTOR = 8'hD1;

    // A path byte of this value is stored as zero.
    localparam logic [7:0] BYTE_NODE_ALIAS = 8'd16;

    // The payload counter saturates here.
    localparam logic [6:0] COUNT_LIMIT = 7'd127;
    // Upper bound on stored path entries from the counter width.
    localparam int         COUNT_DEPTH = 126;

    typedef enum logic [2:0] {
        KIND_MODE    = 3'd0,
        KIND_TASK    = 3'd1,
        KIND_BACK    = 3'd2,
        KIND_START   = 3'd3,
        KIND_PUMP    = 3'd4,
        KIND_MOTOR   = 3'd5,
        KIND_UNKNOWN = 3'd6,
        KIND_READ    = 3'd7
    } t_kind;

endpackage

// File: hdl/uart_command_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_parser_top
// Parses command frames from a received byte stream and stores path tables.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle while input ready is high. A
// received byte is parsed in the cycle it is accepted; a path data byte is
// held until the next byte is accepted and written into the task or back path
// memory at that edge. A frame close or a path read gives one result transfer:
// the first stage holds the registered memory read, the second is the output
// register. Input ready drops only when both stages hold results that the sink
// has not taken, so a stalled sink costs no throughput until two results are
// waiting. Bytes that give no result never occupy a stage.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_top_macros.svh"

module uart_command_frame_parser_top
    import ucfp_pkg::*;
#(
    parameter int PATH_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte [7:0], read_index [13:8], read_back_path [14], zero [15].
    input  logic [15:0] s_axis_tdata,
    // operation [0].
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value [7:0], path_length [14:8], overflow [15].
    output logic [15:0] m_axis_tdata,
    // kind [2:0].
    output logic [2:0]  m_axis_tuser
);

    localparam int         EFF_DEPTH = (PATH_DEPTH < COUNT_DEPTH) ? PATH_DEPTH : COUNT_DEPTH;
    localparam int         ADDR_W    = $clog2(EFF_DEPTH);
    localparam logic [6:0] EFF_LEN   = 7'(EFF_DEPTH);

    logic       r_in_frame,   n_in_frame;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte,  n_held_byte;
    logic [6:0] r_pc,         n_pc;
    logic [7:0] r_code,       n_code;
    logic [7:0] r_first,      n_first;
    logic       r_ovf,        n_ovf;
    logic [6:0] r_task_len,   n_task_len;
    logic [6:0] r_back_len,   n_back_len;

    logic [7:0] r_task_mem [EFF_DEPTH];
    logic [7:0] r_back_mem [EFF_DEPTH];
    logic [7:0] r_task_rd;
    logic [7:0] r_back_rd;

    logic       r_s1_valid;
    logic       r_s1_read;
    logic       r_s1_back;
    logic       r_s1_hit;
    t_kind      r_s1_kind;
    logic [7:0] r_s1_value;
    logic [6:0] r_s1_len;
    logic       r_s1_ovf;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_value;
    logic [6:0] r_out_len;
    logic       r_out_ovf;

    logic        w_accept;
    logic        w_op_read;
    logic [7:0]  w_byte;
    logic [5:0]  w_rd_idx;
    logic        w_rd_back;
    logic [6:0]  w_rd_len;
    logic        w_rd_hit;
    logic [ADDR_W-1:0] w_rd_addr;

    logic        w_hdr;
    logic        w_cls;
    logic        w_take;
    logic        w_is_path;
    logic [6:0]  w_idx;
    logic        w_wr_en;
    logic        w_wr_back;
    logic [7:0]  w_wr_val;
    logic [ADDR_W-1:0] w_wr_addr;

    logic [7:0]  w_code_eff;
    t_kind       w_cls_kind;
    logic [6:0]  w_cls_n;
    logic [6:0]  w_cls_len;
    logic        w_cls_ovf;
    logic [7:0]  w_cls_value;

    logic        w_s1_load;
    logic        w_s1_move;
    logic [7:0]  w_s1_result;

    assign s_axis_tready = !(r_s1_valid && r_out_valid && !m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op_read     = s_axis_tuser;
    assign w_byte        = s_axis_tdata[7:0];
    assign w_rd_idx      = s_axis_tdata[13:8];
    assign w_rd_back     = s_axis_tdata[14];

    assign w_rd_len  = w_rd_back ? r_back_len : r_task_len;
    assign w_rd_hit  = {1'b0, w_rd_idx} < w_rd_len;
    assign w_rd_addr = ADDR_W'(w_rd_idx);

    assign w_hdr = r_held_valid && (r_held_byte == BYTE_HDR_FIRST)
                   && (w_byte == BYTE_HDR_SECOND);
    assign w_cls = r_in_frame && r_held_valid && (r_held_byte == BYTE_TRAILER)
                   && (w_byte == BYTE_TRAILER);
    assign w_take    = r_held_valid && r_in_frame && !w_hdr && !w_cls;
    assign w_is_path = (r_code == CODE_TASK) || (r_code == CODE_BACK);
    assign w_idx     = r_pc - 7'd1;
    assign w_wr_back = (r_code == CODE_BACK);
    assign w_wr_val  = (r_held_byte == BYTE_NODE_ALIAS) ? 8'd0 : r_held_byte;
    assign w_wr_addr = ADDR_W'(w_idx);
    assign w_wr_en   = w_accept && !w_op_read && w_take && (r_pc != 7'd0)
                       && (r_pc < COUNT_LIMIT) && w_is_path && (w_idx < EFF_LEN);

    assign w_code_eff  = (r_pc == 7'd0) ? 8'd0 : r_code;
    assign w_cls_n     = (w_idx > EFF_LEN) ? EFF_LEN : w_idx;
    assign w_cls_value = (r_pc >= 7'd2) ? r_first : 8'd0;

    always_comb begin
        w_cls_kind = KIND_UNKNOWN;
        w_cls_len  = 7'd0;
        w_cls_ovf  = 1'b0;
        case (w_code_eff)
            CODE_MODE:  w_cls_kind = KIND_MODE;
            CODE_START: w_cls_kind = KIND_START;
            CODE_PUMP:  w_cls_kind = KIND_PUMP;
            CODE_MOTOR: w_cls_kind = KIND_MOTOR;
            CODE_TASK: begin
                w_cls_kind = KIND_TASK;
                w_cls_len  = w_cls_n;
                w_cls_ovf  = r_ovf;
            end
            CODE_BACK: begin
                w_cls_kind = KIND_BACK;
                w_cls_len  = w_cls_n;
                w_cls_ovf  = r_ovf;
            end
            default:    w_cls_kind = KIND_UNKNOWN;
        endcase
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_pc         = r_pc;
        n_code       = r_code;
        n_first      = r_first;
        n_ovf        = r_ovf;
        n_task_len   = r_task_len;
        n_back_len   = r_back_len;
        if (w_accept && !w_op_read) begin
            if (w_hdr) begin
                n_in_frame   = 1'b1;
                n_held_valid = 1'b0;
                n_pc         = 7'd0;
                n_code       = 8'd0;
                n_first      = 8'd0;
                n_ovf        = 1'b0;
            end else if (w_cls) begin
                n_in_frame   = 1'b0;
                n_held_valid = 1'b0;
                if (w_cls_kind == KIND_TASK) begin
                    n_task_len = w_cls_n;
                end
                if (w_cls_kind == KIND_BACK) begin
                    n_back_len = w_cls_n;
                end
            end else begin
                if (w_take) begin
                    if (r_pc == 7'd0) begin
                        n_code = r_held_byte;
                        n_pc   = 7'd1;
                    end else if (r_pc >= COUNT_LIMIT) begin
                        if (w_is_path) begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        if (w_idx == 7'd0) begin
                            n_first = r_held_byte;
                        end
                        if (w_is_path && (w_idx >= EFF_LEN)) begin
                            n_ovf = 1'b1;
                        end
                        n_pc = r_pc + 7'd1;
                    end
                end
                n_held_byte  = w_byte;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'd0;
            r_pc         <= 7'd0;
            r_code       <= 8'd0;
            r_first      <= 8'd0;
            r_ovf        <= 1'b0;
            r_task_len   <= 7'd0;
            r_back_len   <= 7'd0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_pc         <= n_pc;
            r_code       <= n_code;
            r_first      <= n_first;
            r_ovf        <= n_ovf;
            r_task_len   <= n_task_len;
            r_back_len   <= n_back_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && !w_wr_back) begin
            r_task_mem[w_wr_addr] <= w_wr_val;
        end
        if (w_accept && w_op_read && !w_rd_back) begin
            r_task_rd <= r_task_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && w_wr_back) begin
            r_back_mem[w_wr_addr] <= w_wr_val;
        end
        if (w_accept && w_op_read && w_rd_back) begin
            r_back_rd <= r_back_mem[w_rd_addr];
        end
    end

    assign w_s1_load = w_accept && (w_op_read || w_cls);
    assign w_s1_move = r_s1_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_read <= w_op_read;
            r_s1_back <= w_rd_back;
            r_s1_hit  <= w_rd_hit;
            if (w_op_read) begin
                r_s1_kind  <= KIND_READ;
                r_s1_value <= 8'd0;
                r_s1_len   <= w_rd_len;
                r_s1_ovf   <= 1'b0;
            end else begin
                r_s1_kind  <= w_cls_kind;
                r_s1_value <= w_cls_value;
                r_s1_len   <= w_cls_len;
                r_s1_ovf   <= w_cls_ovf;
            end
        end
    end

    always_comb begin
        w_s1_result = r_s1_value;
        if (r_s1_read) begin
            if (!r_s1_hit) begin
                w_s1_result = 8'd0;
            end else if (r_s1_back) begin
                w_s1_result = r_back_rd;
            end else begin
                w_s1_result = r_task_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_kind  <= r_s1_kind;
            r_out_value <= w_s1_result;
            r_out_len   <= r_s1_len;
            r_out_ovf   <= r_s1_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ovf, r_out_len, r_out_value};
    assign m_axis_tuser  = r_out_kind;

    `UCFP_ASSERT(a_len_bound, (r_task_len <= EFF_LEN) && (r_back_len <= EFF_LEN), "path length beyond store depth")
    `UCFP_ASSERT(a_read_enters_stage, (w_accept && w_op_read) |=> (r_s1_valid && r_s1_read), "read transfer did not enter first stage")
    `UCFP_ASSERT(a_header_restarts, (w_accept && !w_op_read && w_hdr) |=> (r_in_frame && (r_pc == 7'd0) && !r_held_valid), "header did not restart the frame")
    `UCFP_ASSERT(a_ovf_path_only, (m_axis_tvalid && m_axis_tdata[15]) |-> ((m_axis_tuser == KIND_TASK) || (m_axis_tuser == KIND_BACK)), "overflow flagged on a non-path result")
    `UCFP_ASSERT_ALWAYS(a_reset_idle, (!$past(i_rst_n)) |-> (!r_s1_valid && !r_out_valid), "result stages not empty after reset")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the command frame parser. A driver sends
// received bytes and path reads from a queue. A parser model in this file
// predicts every reply, and a monitor checks each reply transfer against
// the oldest prediction. Both sides idle at random in several phases, and
// one long sink hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module tb;
    import ucfp_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int USED_DEPTH  = (STORE_DEPTH < COUNT_DEPTH) ? STORE_DEPTH : COUNT_DEPTH;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 395;

    typedef enum logic {
        OP_RX_BYTE = 1'b0,
        OP_READ    = 1'b1
    } op_e;

    typedef struct packed {
        op_e        op;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
        logic       read_back;
    } rx_item_t;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [6:0] path_length;
        logic       overflow;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    rx_item_t rx_items[$];
    reply_t   pending_replies[$];
    rx_item_t shown_item;
    int       src_idle_pct = 0;
    int       snk_stall_pct = 0;
    logic     hold_active = 1'b0;
    int       mismatch_count = 0;
    int       cycle_count = 0;

    // Parser state as seen by the prediction.
    logic       pr_in_frame = 1'b0;
    logic       pr_held_valid = 1'b0;
    logic [7:0] pr_held_byte = '0;
    int         pr_count = 0;
    logic [7:0] pr_code = '0;
    logic [7:0] pr_first = '0;
    logic       pr_overflow = 1'b0;
    logic [7:0] task_mem [STORE_DEPTH];
    logic [7:0] back_mem [STORE_DEPTH];
    int         task_len = 0;
    int         back_len = 0;

    uart_command_frame_parser_top #(
        .PATH_DEPTH(STORE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_parser_reply(input rx_item_t it);
        reply_t     r;
        logic [7:0] b;
        logic [7:0] code;
        int         n;
        int         slot;
        r = '0;
        if (it.op == OP_READ) begin
            n = it.read_back ? back_len : task_len;
            r.kind = KIND_READ;
            if (it.read_index < n) begin
                r.value = it.read_back ? back_mem[it.read_index] : task_mem[it.read_index];
            end
            r.path_length = n[6:0];
            pending_replies.push_back(r);
            return;
        end
        b = it.rx_byte;
        if (pr_held_valid && pr_held_byte == BYTE_HDR_FIRST && b == BYTE_HDR_SECOND) begin
            pr_in_frame = 1'b1;
            pr_held_valid = 1'b0;
            pr_count = 0;
            pr_code = '0;
            pr_first = '0;
            pr_overflow = 1'b0;
        end else if (pr_in_frame && pr_held_valid && pr_held_byte == BYTE_TRAILER
                     && b == BYTE_TRAILER) begin
            code = (pr_count == 0) ? 8'h00 : pr_code;
            r.kind = KIND_UNKNOWN;
            case (code)
                CODE_MODE: begin
                    r.kind = KIND_MODE;
                end
                CODE_START: begin
                    r.kind = KIND_START;
                end
                CODE_PUMP: begin
                    r.kind = KIND_PUMP;
                end
                CODE_MOTOR: begin
                    r.kind = KIND_MOTOR;
                end
                CODE_TASK, CODE_BACK: begin
                    n = (pr_count - 1 > USED_DEPTH) ? USED_DEPTH : pr_count - 1;
                    if (code == CODE_TASK) begin
                        task_len = n;
                        r.kind = KIND_TASK;
                    end else begin
                        back_len = n;
                        r.kind = KIND_BACK;
                    end
                    r.path_length = n[6:0];
                    r.overflow = pr_overflow;
                end
                default: begin
                end
            endcase
            r.value = (pr_count >= 2) ? pr_first : 8'h00;
            pending_replies.push_back(r);
            pr_in_frame = 1'b0;
            pr_held_valid = 1'b0;
        end else begin
            if (pr_held_valid && pr_in_frame) begin
                if (pr_count == 0) begin
                    pr_code = pr_held_byte;
                    pr_count = 1;
                end else if (pr_count >= COUNT_LIMIT) begin
                    if (pr_code == CODE_TASK || pr_code == CODE_BACK) begin
                        pr_overflow = 1'b1;
                    end
                end else begin
                    slot = pr_count - 1;
                    if (slot == 0) begin
                        pr_first = pr_held_byte;
                    end
                    if (pr_code == CODE_TASK || pr_code == CODE_BACK) begin
                        if (slot < USED_DEPTH) begin
                            if (pr_code == CODE_TASK) begin
                                task_mem[slot] = (pr_held_byte == BYTE_NODE_ALIAS) ?
                                                 8'h00 : pr_held_byte;
                            end else begin
                                back_mem[slot] = (pr_held_byte == BYTE_NODE_ALIAS) ?
                                                 8'h00 : pr_held_byte;
                            end
                        end else begin
                            pr_overflow = 1'b1;
                        end
                    end
                    pr_count = pr_count + 1;
                end
            end
            pr_held_byte = b;
            pr_held_valid = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_parser_reply(shown_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    shown_item = rx_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, shown_item.read_back, shown_item.read_index,
                                     shown_item.rx_byte};
                    s_axis_tuser <= shown_item.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        reply_t got;
        reply_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = t_kind'(m_axis_tuser);
                got.value = m_axis_tdata[7:0];
                got.path_length = m_axis_tdata[14:8];
                got.overflow = m_axis_tdata[15];
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply with none expected:", $realtime,
                             " kind %0d value %02h len %0d ovf %0d",
                             got.kind, got.value, got.path_length, got.overflow);
                    mismatch_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value
                        || got.path_length !== want.path_length
                        || got.overflow !== want.overflow) begin
                        $display("%0t: expected kind %0d value %02h len %0d ovf %0d,",
                                 $realtime, want.kind, want.value, want.path_length,
                                 want.overflow,
                                 " got kind %0d value %02h len %0d ovf %0d",
                                 got.kind, got.value, got.path_length, got.overflow);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Fields that the operation ignores still get random values.
    function automatic void push_byte(input logic [7:0] b);
        rx_item_t it;
        it.op = OP_RX_BYTE;
        it.rx_byte = b;
        it.read_index = 6'($urandom_range(0, 63));
        it.read_back = 1'($urandom_range(0, 1));
        rx_items.push_back(it);
    endfunction

    function automatic void push_read(input int index, input logic back);
        rx_item_t it;
        it.op = OP_READ;
        it.rx_byte = 8'($urandom_range(0, 255));
        it.read_index = index[5:0];
        it.read_back = back;
        rx_items.push_back(it);
    endfunction

    function automatic logic [7:0] random_data_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return BYTE_NODE_ALIAS;
        end else if (r < 20) begin
            return BYTE_TRAILER;
        end else if (r < 23) begin
            return BYTE_HDR_FIRST;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Returns the number of transfers queued.
    function automatic int push_frame(input logic [7:0] code, input int ndata,
                                      input logic closed);
        push_byte(BYTE_HDR_FIRST);
        push_byte(BYTE_HDR_SECOND);
        push_byte(code);
        for (int i = 0; i < ndata; i++) begin
            push_byte(random_data_byte());
        end
        if (closed) begin
            push_byte(BYTE_TRAILER);
            push_byte(BYTE_TRAILER);
        end
        return ndata + (closed ? 5 : 3);
    endfunction

    task automatic queue_random_traffic(input int budget);
        int         queued;
        int         r;
        int         ndata;
        logic [7:0] code;
        queued = 0;
        while (queued < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55 || (r >= 75 && r < 85)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: code = CODE_TASK;
                    3, 4, 5: code = CODE_BACK;
                    6:       code = ($urandom_range(0, 1) != 0) ? CODE_MODE : CODE_START;
                    7:       code = ($urandom_range(0, 1) != 0) ? CODE_PUMP : CODE_MOTOR;
                    default: code = 8'($urandom_range(0, 255));
                endcase
                r = $urandom_range(0, 99);
                if (r < 88) begin
                    ndata = $urandom_range(0, 12);
                end else if (r < 95) begin
                    ndata = $urandom_range(13, 66);
                end else begin
                    case ($urandom_range(0, 8))
                        0: ndata = 63;
                        1: ndata = 64;
                        2: ndata = 65;
                        3: ndata = 66;
                        4: ndata = 125;
                        5: ndata = 126;
                        6: ndata = 127;
                        7: ndata = 128;
                        default: ndata = 140;
                    endcase
                end
                queued += push_frame(code, ndata, r < 55 || $urandom_range(0, 3) != 0);
            end else if (r < 75) begin
                push_read(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
                queued++;
            end else if (r < 92) begin
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    case ($urandom_range(0, 3))
                        0: push_byte(BYTE_TRAILER);
                        1: push_byte(BYTE_HDR_SECOND);
                        default: push_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                push_byte(BYTE_HDR_FIRST);
                push_byte(BYTE_HDR_SECOND);
                if ($urandom_range(0, 1) != 0) begin
                    push_byte(8'($urandom_range(0, 255)));
                end
                push_byte(BYTE_TRAILER);
                push_byte(BYTE_TRAILER);
                queued += 4;
            end
        end
    endtask

    task automatic drain_stimulus();
        while (rx_items.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin : timeout
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[uart_command_frame_parser_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        int dummy;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reads of empty paths, a close outside a frame, an empty frame.
        push_read(0, 1'b0);
        push_read(63, 1'b1);
        push_byte(BYTE_TRAILER);
        push_byte(BYTE_TRAILER);
        push_byte(BYTE_HDR_FIRST);
        push_byte(BYTE_HDR_SECOND);
        push_byte(BYTE_TRAILER);
        push_byte(BYTE_TRAILER);
        // Task path with the alias byte and both byte extremes.
        push_byte(BYTE_HDR_FIRST);
        push_byte(BYTE_HDR_SECOND);
        push_byte(CODE_TASK);
        push_byte(BYTE_NODE_ALIAS);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(BYTE_TRAILER);
        push_byte(BYTE_TRAILER);
        push_read(1, 1'b0);
        // A back path frame restarted by a header before it closes.
        push_byte(BYTE_HDR_FIRST);
        push_byte(BYTE_HDR_SECOND);
        push_byte(CODE_BACK);
        push_byte(8'h01);
        push_byte(BYTE_HDR_FIRST);
        push_byte(BYTE_HDR_SECOND);
        push_byte(CODE_MOTOR);
        push_byte(8'h05);
        push_byte(BYTE_TRAILER);
        push_byte(BYTE_TRAILER);
        push_read(0, 1'b1);
        drain_stimulus();

        src_idle_pct = 0;
        snk_stall_pct = 0;
        queue_random_traffic(PHASE_ITEMS);
        drain_stimulus();

        src_idle_pct = 78;
        queue_random_traffic(PHASE_ITEMS);
        drain_stimulus();

        src_idle_pct = 0;
        snk_stall_pct = 78;
        queue_random_traffic(PHASE_ITEMS);
        drain_stimulus();

        src_idle_pct = 19;
        snk_stall_pct = 19;
        queue_random_traffic(PHASE_ITEMS);
        drain_stimulus();

        // The sink holds off while reads keep arriving, so the block fills up.
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_active = 1'b1;
        for (int i = 0; i < 40; i++) begin
            push_read($urandom_range(0, 63), 1'($urandom_range(0, 1)));
        end
        dummy = push_frame(CODE_TASK, 6, 1'b1);
        repeat (300) @(negedge i_clk);
        hold_active = 1'b0;
        drain_stimulus();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[uart_command_frame_parser_top] OK");
        end else begin
            $display("[uart_command_frame_parser_top] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/ucfp_pkg.sv
hdl/uart_command_frame_parser_top.sv
dv/tb.sv
